### rtl/sit_pkg.sv
// Shared types and constants for the segment intersection test core.
// No dependencies; imported by every module under rtl.
package sit_pkg;

    // Default coordinate width of one endpoint field
    localparam int COORD_WIDTH_DEF = 16;

    // Coordinate differences formed in the first stage
    localparam int NUM_DIFF = 12;
    localparam int DIFF_AX  = 0;   // a2.x - a1.x
    localparam int DIFF_AY  = 1;   // a2.y - a1.y
    localparam int DIFF_B1X = 2;   // b1.x - a1.x
    localparam int DIFF_B1Y = 3;   // b1.y - a1.y
    localparam int DIFF_B2X = 4;   // b2.x - a1.x
    localparam int DIFF_B2Y = 5;   // b2.y - a1.y
    localparam int DIFF_BX  = 6;   // b2.x - b1.x
    localparam int DIFF_BY  = 7;   // b2.y - b1.y
    localparam int DIFF_A1X = 8;   // a1.x - b1.x
    localparam int DIFF_A1Y = 9;   // a1.y - b1.y
    localparam int DIFF_A2X = 10;  // a2.x - b1.x
    localparam int DIFF_A2Y = 11;  // a2.y - b1.y

    // Four orientation tests, each a pair of cross-product terms
    localparam int NUM_ORIENT = 4;
    localparam int NUM_PROD   = 2 * NUM_ORIENT;

    // Bounding-box containment of each endpoint in the other segment
    typedef struct packed {
        logic b1_on_a;
        logic b2_on_a;
        logic a1_on_b;
        logic a2_on_b;
    } box_flags_t;

endpackage

### rtl/sit_diff_stage.sv
// Stage one: endpoint differences and bounding-box checks, registered.
// Depends on sit_pkg.
module sit_diff_stage
    import sit_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   valid_in,
    input  logic signed [COORD_WIDTH-1:0]          seg_a_x1,
    input  logic signed [COORD_WIDTH-1:0]          seg_a_y1,
    input  logic signed [COORD_WIDTH-1:0]          seg_a_x2,
    input  logic signed [COORD_WIDTH-1:0]          seg_a_y2,
    input  logic signed [COORD_WIDTH-1:0]          seg_b_x1,
    input  logic signed [COORD_WIDTH-1:0]          seg_b_y1,
    input  logic signed [COORD_WIDTH-1:0]          seg_b_x2,
    input  logic signed [COORD_WIDTH-1:0]          seg_b_y2,
    output logic                                   valid_out,
    output logic [NUM_DIFF-1:0][COORD_WIDTH:0]     diff_out,
    output box_flags_t                             box_out
);

    localparam int DW = COORD_WIDTH + 1;

    logic                            valid_reg;
    logic [NUM_DIFF-1:0][DW-1:0]     diff_reg;
    logic [NUM_DIFF-1:0][DW-1:0]     diff_next;
    box_flags_t                      box_reg;
    box_flags_t                      box_next;

    // Sign-extended difference, never overflows DW bits
    function automatic logic [DW-1:0] sub(input logic signed [COORD_WIDTH-1:0] p,
                                          input logic signed [COORD_WIDTH-1:0] q);
        sub = DW'(p) - DW'(q);
    endfunction

    // r within the closed interval spanned by p and q
    function automatic logic between(input logic signed [COORD_WIDTH-1:0] r,
                                     input logic signed [COORD_WIDTH-1:0] p,
                                     input logic signed [COORD_WIDTH-1:0] q);
        between = ((r >= p) && (r <= q)) || ((r >= q) && (r <= p));
    endfunction

    // Differences against a1 and b1
    always_comb
    begin
        diff_next[DIFF_AX]  = sub(seg_a_x2, seg_a_x1);
        diff_next[DIFF_AY]  = sub(seg_a_y2, seg_a_y1);
        diff_next[DIFF_B1X] = sub(seg_b_x1, seg_a_x1);
        diff_next[DIFF_B1Y] = sub(seg_b_y1, seg_a_y1);
        diff_next[DIFF_B2X] = sub(seg_b_x2, seg_a_x1);
        diff_next[DIFF_B2Y] = sub(seg_b_y2, seg_a_y1);
        diff_next[DIFF_BX]  = sub(seg_b_x2, seg_b_x1);
        diff_next[DIFF_BY]  = sub(seg_b_y2, seg_b_y1);
        diff_next[DIFF_A1X] = sub(seg_a_x1, seg_b_x1);
        diff_next[DIFF_A1Y] = sub(seg_a_y1, seg_b_y1);
        diff_next[DIFF_A2X] = sub(seg_a_x2, seg_b_x1);
        diff_next[DIFF_A2Y] = sub(seg_a_y2, seg_b_y1);
    end

    // Box checks for the collinear cases
    always_comb
    begin
        box_next.b1_on_a = between(seg_b_x1, seg_a_x1, seg_a_x2) &&
                           between(seg_b_y1, seg_a_y1, seg_a_y2);
        box_next.b2_on_a = between(seg_b_x2, seg_a_x1, seg_a_x2) &&
                           between(seg_b_y2, seg_a_y1, seg_a_y2);
        box_next.a1_on_b = between(seg_a_x1, seg_b_x1, seg_b_x2) &&
                           between(seg_a_y1, seg_b_y1, seg_b_y2);
        box_next.a2_on_b = between(seg_a_x2, seg_b_x1, seg_b_x2) &&
                           between(seg_a_y2, seg_b_y1, seg_b_y2);
    end

    // Valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        diff_reg <= diff_next;
        box_reg  <= box_next;
    end

    assign valid_out = valid_reg;
    assign diff_out  = diff_reg;
    assign box_out   = box_reg;

endmodule

### rtl/sit_prod_stage.sv
// Stage two: cross-product terms of the four orientation tests, registered.
// Depends on sit_pkg.
module sit_prod_stage
    import sit_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        valid_in,
    input  logic [NUM_DIFF-1:0][COORD_WIDTH:0]          diff_in,
    input  box_flags_t                                  box_in,
    output logic                                        valid_out,
    output logic [NUM_PROD-1:0][2*COORD_WIDTH+1:0]      prod_out,
    output box_flags_t                                  box_out
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;

    logic                            valid_reg;
    logic [NUM_PROD-1:0][PW-1:0]     prod_reg;
    logic [NUM_PROD-1:0][PW-1:0]     prod_next;
    box_flags_t                      box_reg;

    // Signed DW x DW product
    function automatic logic [PW-1:0] mul(input logic [DW-1:0] p, input logic [DW-1:0] q);
        logic signed [PW-1:0] r;
        r   = $signed(p) * $signed(q);
        mul = r;
    endfunction

    // Term pairs: even index is the left term, odd index the right term
    always_comb
    begin
        // a1, a2 against b1
        prod_next[0] = mul(diff_in[DIFF_AX], diff_in[DIFF_B1Y]);
        prod_next[1] = mul(diff_in[DIFF_AY], diff_in[DIFF_B1X]);
        // a1, a2 against b2
        prod_next[2] = mul(diff_in[DIFF_AX], diff_in[DIFF_B2Y]);
        prod_next[3] = mul(diff_in[DIFF_AY], diff_in[DIFF_B2X]);
        // b1, b2 against a1
        prod_next[4] = mul(diff_in[DIFF_BX], diff_in[DIFF_A1Y]);
        prod_next[5] = mul(diff_in[DIFF_BY], diff_in[DIFF_A1X]);
        // b1, b2 against a2
        prod_next[6] = mul(diff_in[DIFF_BX], diff_in[DIFF_A2Y]);
        prod_next[7] = mul(diff_in[DIFF_BY], diff_in[DIFF_A2X]);
    end

    // Valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        box_reg  <= box_in;
    end

    assign valid_out = valid_reg;
    assign prod_out  = prod_reg;
    assign box_out   = box_reg;

endmodule

### rtl/sit_decide_stage.sv
// Stage three: orientation signs and the final hit decision, registered.
// Depends on sit_pkg.
module sit_decide_stage
    import sit_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        valid_in,
    input  logic [NUM_PROD-1:0][2*COORD_WIDTH+1:0]      prod_in,
    input  box_flags_t                                  box_in,
    output logic                                        valid_out,
    output logic                                        hit_out
);

    logic [NUM_ORIENT-1:0] gt;
    logic [NUM_ORIENT-1:0] lt;
    logic [NUM_ORIENT-1:0] zero;
    logic                  proper;
    logic                  hit_next;
    logic                  hit_reg;
    logic                  valid_reg;

    // Sign of each cross product, from comparing its two terms
    always_comb
    begin
        for (int k = 0; k < NUM_ORIENT; k++)
        begin
            gt[k]   = $signed(prod_in[2*k]) > $signed(prod_in[2*k+1]);
            lt[k]   = $signed(prod_in[2*k]) < $signed(prod_in[2*k+1]);
            zero[k] = !gt[k] && !lt[k];
        end
    end

    // Proper crossing, or an endpoint collinear and inside the other box
    always_comb
    begin
        proper   = ((gt[0] != gt[1]) || (lt[0] != lt[1])) &&
                   ((gt[2] != gt[3]) || (lt[2] != lt[3]));
        hit_next = proper ||
                   (zero[0] && box_in.b1_on_a) ||
                   (zero[1] && box_in.b2_on_a) ||
                   (zero[2] && box_in.a1_on_b) ||
                   (zero[3] && box_in.a2_on_b);
    end

    // Result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    // Result value
    always_ff @(posedge clk)
    begin
        hit_reg <= hit_next;
    end

    assign valid_out = valid_reg;
    assign hit_out   = hit_reg;

endmodule

### rtl/segment_intersection_test_core.sv
// Segment intersection test core: exact integer orientation test.
// A request taken at a clock edge is registered in the diff, product and decide stages in turn before its done strobe.
// Throughput: one request per cycle through the diff, product and decide stages.
// busy stays low; the receiver cannot stall, so done lasts exactly one cycle.
// Reset (rst_n low, asynchronous) clears the stage valid bits; requests in flight are dropped.
// Depends on sit_pkg, sit_diff_stage, sit_prod_stage, sit_decide_stage.
module segment_intersection_test_core
    import sit_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] seg_a_x1,
    input  logic signed [COORD_WIDTH-1:0] seg_a_y1,
    input  logic signed [COORD_WIDTH-1:0] seg_a_x2,
    input  logic signed [COORD_WIDTH-1:0] seg_a_y2,
    input  logic signed [COORD_WIDTH-1:0] seg_b_x1,
    input  logic signed [COORD_WIDTH-1:0] seg_b_y1,
    input  logic signed [COORD_WIDTH-1:0] seg_b_x2,
    input  logic signed [COORD_WIDTH-1:0] seg_b_y2,
    output logic                          done,
    output logic                          intersects
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;

    logic                            s1_valid;
    logic [NUM_DIFF-1:0][DW-1:0]     s1_diff;
    box_flags_t                      s1_box;
    logic                            s2_valid;
    logic [NUM_PROD-1:0][PW-1:0]     s2_prod;
    box_flags_t                      s2_box;

    // Pipeline never stalls
    assign busy = 1'b0;

    // Endpoint differences and box checks
    sit_diff_stage #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_diff (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (start && !busy),
        .seg_a_x1  (seg_a_x1),
        .seg_a_y1  (seg_a_y1),
        .seg_a_x2  (seg_a_x2),
        .seg_a_y2  (seg_a_y2),
        .seg_b_x1  (seg_b_x1),
        .seg_b_y1  (seg_b_y1),
        .seg_b_x2  (seg_b_x2),
        .seg_b_y2  (seg_b_y2),
        .valid_out (s1_valid),
        .diff_out  (s1_diff),
        .box_out   (s1_box)
    );

    // Cross-product terms
    sit_prod_stage #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_prod (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (s1_valid),
        .diff_in   (s1_diff),
        .box_in    (s1_box),
        .valid_out (s2_valid),
        .prod_out  (s2_prod),
        .box_out   (s2_box)
    );

    // Signs and decision
    sit_decide_stage #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_decide (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (s2_valid),
        .prod_in   (s2_prod),
        .box_in    (s2_box),
        .valid_out (done),
        .hit_out   (intersects)
    );

    // A result only follows an earlier matching request
    a_done_has_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 3))
        else $error("done without a matching request");

    // Segments sharing a start point always hit
    a_shared_endpoint_hits: assert property (@(posedge clk) disable iff (!rst_n)
        (start && (seg_a_x1 == seg_b_x1) && (seg_a_y1 == seg_b_y1))
        |-> ##3 (done && intersects))
        else $error("shared endpoint reported as a miss");

    // A segment and its reversed copy always hit
    a_same_segment_hits: assert property (@(posedge clk) disable iff (!rst_n)
        (start && (seg_a_x1 == seg_b_x2) && (seg_a_y1 == seg_b_y2) &&
         (seg_a_x2 == seg_b_x1) && (seg_a_y2 == seg_b_y1))
        |-> ##3 (done && intersects))
        else $error("reversed copy of a segment reported as a miss");

    // Two distinct single points never hit
    a_distinct_points_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (start && (seg_a_x1 == seg_a_x2) && (seg_a_y1 == seg_a_y2) &&
         (seg_b_x1 == seg_b_x2) && (seg_b_y1 == seg_b_y2) &&
         ((seg_a_x1 != seg_b_x1) || (seg_a_y1 != seg_b_y1)))
        |-> ##3 (done && !intersects))
        else $error("distinct points reported as a hit");

endmodule

### test/tb_segment_intersection_test_core.sv
// Self-checking testbench for segment_intersection_test_core: exact segment-pair hit test.
// Holds its own orientation-based predictor and checks each done strobe in order.
// Depends on sit_pkg and the segment_intersection_test_core RTL.
module tb_segment_intersection_test_core
    import sit_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW             = COORD_WIDTH_DEF;
    localparam int C_MAX          = 2 ** (CW - 1) - 1;
    localparam int C_MIN          = -(2 ** (CW - 1));
    localparam int PIPE_LATENCY   = 3;
    localparam int WATCHDOG_LIMIT = 1000;

    typedef logic signed [CW-1:0] coord_t;

    // one request: segment A then segment B, same order as the ports
    typedef struct packed {
        coord_t ax1;
        coord_t ay1;
        coord_t ax2;
        coord_t ay2;
        coord_t bx1;
        coord_t by1;
        coord_t bx2;
        coord_t by2;
    } seg_pair_t;

    typedef struct {
        seg_pair_t pair;
        bit        hit;
    } hit_record_t;

    // sign of a cross product
    typedef enum int {
        TURN_RIGHT = -1,
        TURN_NONE  = 0,
        TURN_LEFT  = 1
    } turn_t;

    logic   clk;
    logic   rst_n;
    logic   start;
    logic   busy;
    coord_t seg_a_x1;
    coord_t seg_a_y1;
    coord_t seg_a_x2;
    coord_t seg_a_y2;
    coord_t seg_b_x1;
    coord_t seg_b_y1;
    coord_t seg_b_x2;
    coord_t seg_b_y2;
    logic   done;
    logic   intersects;

    hit_record_t hit_expected_q[$];
    hit_record_t head_rec;
    bit          gaps_on;
    int          pairs_sent;
    int          pairs_checked;
    int          hits_seen;
    int          errors;
    int          quiet_cycles;

    segment_intersection_test_core #(
        .COORD_WIDTH (CW)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .seg_a_x1   (seg_a_x1),
        .seg_a_y1   (seg_a_y1),
        .seg_a_x2   (seg_a_x2),
        .seg_a_y2   (seg_a_y2),
        .seg_b_x1   (seg_b_x1),
        .seg_b_y1   (seg_b_y1),
        .seg_b_x2   (seg_b_x2),
        .seg_b_y2   (seg_b_y2),
        .done       (done),
        .intersects (intersects)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // direction of r as seen along p -> q; products compared, not subtracted
    function automatic turn_t turn_of(input longint px, input longint py,
                                      input longint qx, input longint qy,
                                      input longint rx, input longint ry);
        longint lhs;
        longint rhs;
        lhs = (qx - px) * (ry - py);
        rhs = (qy - py) * (rx - px);
        if (lhs > rhs)
            return TURN_LEFT;
        if (lhs < rhs)
            return TURN_RIGHT;
        return TURN_NONE;
    endfunction

    // r (already collinear with p..q) lies inside their bounding box
    function automatic bit on_extent(input longint px, input longint py,
                                     input longint qx, input longint qy,
                                     input longint rx, input longint ry);
        return rx >= ((px < qx) ? px : qx) && rx <= ((px > qx) ? px : qx) &&
               ry >= ((py < qy) ? py : qy) && ry <= ((py > qy) ? py : qy);
    endfunction

    function automatic bit segments_touch(input seg_pair_t p);
        turn_t t_b1;
        turn_t t_b2;
        turn_t t_a1;
        turn_t t_a2;
        t_b1 = turn_of(p.ax1, p.ay1, p.ax2, p.ay2, p.bx1, p.by1);
        t_b2 = turn_of(p.ax1, p.ay1, p.ax2, p.ay2, p.bx2, p.by2);
        t_a1 = turn_of(p.bx1, p.by1, p.bx2, p.by2, p.ax1, p.ay1);
        t_a2 = turn_of(p.bx1, p.by1, p.bx2, p.by2, p.ax2, p.ay2);
        // proper crossing: each segment straddles the other's line
        if (t_b1 != t_b2 && t_a1 != t_a2)
            return 1'b1;
        // an endpoint lying on the other segment
        if (t_b1 == TURN_NONE && on_extent(p.ax1, p.ay1, p.ax2, p.ay2, p.bx1, p.by1))
            return 1'b1;
        if (t_b2 == TURN_NONE && on_extent(p.ax1, p.ay1, p.ax2, p.ay2, p.bx2, p.by2))
            return 1'b1;
        if (t_a1 == TURN_NONE && on_extent(p.bx1, p.by1, p.bx2, p.by2, p.ax1, p.ay1))
            return 1'b1;
        if (t_a2 == TURN_NONE && on_extent(p.bx1, p.by1, p.bx2, p.by2, p.ax2, p.ay2))
            return 1'b1;
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic int rand_span(input int lo, input int hi);
        return int'($urandom_range(hi - lo)) + lo;
    endfunction

    function automatic seg_pair_t mk_pair(input int ax1, input int ay1,
                                          input int ax2, input int ay2,
                                          input int bx1, input int by1,
                                          input int bx2, input int by2);
        seg_pair_t p;
        p.ax1 = coord_t'(ax1);
        p.ay1 = coord_t'(ay1);
        p.ax2 = coord_t'(ax2);
        p.ay2 = coord_t'(ay2);
        p.bx1 = coord_t'(bx1);
        p.by1 = coord_t'(by1);
        p.bx2 = coord_t'(bx2);
        p.by2 = coord_t'(by2);
        return p;
    endfunction

    function automatic int pick_extreme();
        case ($urandom_range(6))
            0:       return C_MIN;
            1:       return C_MIN + 1;
            2:       return -1;
            3:       return 0;
            4:       return 1;
            5:       return C_MAX - 1;
            default: return C_MAX;
        endcase
    endfunction

    // mix of full-range noise, tiny grids, points built on a common line,
    // range corners and mid-range pairs
    function automatic seg_pair_t make_random_pair();
        int        kind;
        int        x0;
        int        y0;
        int        dx;
        int        dy;
        int        k;
        seg_pair_t p;
        kind = $urandom_range(99);
        if (kind < 20)
        begin
            p = {$urandom, $urandom, $urandom, $urandom};
        end
        else if (kind < 45)
        begin
            p = mk_pair(rand_span(-6, 6), rand_span(-6, 6), rand_span(-6, 6),
                        rand_span(-6, 6), rand_span(-6, 6), rand_span(-6, 6),
                        rand_span(-6, 6), rand_span(-6, 6));
        end
        else if (kind < 75)
        begin
            // A on a line, B1 on the same line near or past A's ends
            x0 = rand_span(-1000, 1000);
            y0 = rand_span(-1000, 1000);
            dx = rand_span(-20, 20);
            dy = rand_span(-20, 20);
            k  = rand_span(1, 20);
            p  = mk_pair(x0, y0, x0 + k * dx, y0 + k * dy, 0, 0, 0, 0);
            k  = rand_span(-2, k + 2);
            p.bx1 = coord_t'(x0 + k * dx);
            p.by1 = coord_t'(y0 + k * dy);
            if ($urandom_range(1) == 0)
            begin
                k = rand_span(-4, 24);
                p.bx2 = coord_t'(x0 + k * dx);
                p.by2 = coord_t'(y0 + k * dy);
            end
            else
            begin
                p.bx2 = coord_t'(x0 + rand_span(-500, 500));
                p.by2 = coord_t'(y0 + rand_span(-500, 500));
            end
            if ($urandom_range(1) == 0)
                p = {p[4*CW-1:0], p[8*CW-1:4*CW]};
        end
        else if (kind < 85)
        begin
            p = mk_pair(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
                        pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme());
        end
        else
        begin
            p = mk_pair(rand_span(-64, 64), rand_span(-64, 64), rand_span(-64, 64),
                        rand_span(-64, 64), rand_span(-64, 64), rand_span(-64, 64),
                        rand_span(-64, 64), rand_span(-64, 64));
        end
        return p;
    endfunction

    // issue one request, wait for acceptance, then maybe idle a short burst
    task automatic send_pair(input seg_pair_t p);
        hit_record_t rec;
        start <= 1'b1;
        {seg_a_x1, seg_a_y1, seg_a_x2, seg_a_y2,
         seg_b_x1, seg_b_y1, seg_b_x2, seg_b_y2} <= p;
        do
            @(posedge clk);
        while (busy);
        rec.pair = p;
        rec.hit  = segments_touch(p);
        hit_expected_q.push_back(rec);
        pairs_sent++;
        if (gaps_on && $urandom_range(3) == 0)
        begin
            start <= 1'b0;
            {seg_a_x1, seg_a_y1, seg_a_x2, seg_a_y2,
             seg_b_x1, seg_b_y1, seg_b_x2, seg_b_y2} <= {$urandom, $urandom, $urandom, $urandom};
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_directed_corners();
        send_pair(mk_pair(-10, -10, 10, 10, -10, 10, 10, -10));   // X crossing
        send_pair(mk_pair(0, 0, 10, 0, 0, 1, 10, 1));             // parallel, apart
        send_pair(mk_pair(0, 0, 10, 10, 5, 5, 20, 20));           // collinear overlap
        send_pair(mk_pair(0, 0, 5, 0, 5, 0, 9, 0));               // collinear, one shared point
        send_pair(mk_pair(0, 0, 4, 0, 5, 0, 9, 0));               // collinear, gap of one
        send_pair(mk_pair(0, 0, 4, 4, 4, 4, 8, 0));               // shared endpoint
        send_pair(mk_pair(0, 0, 10, 0, 5, 0, 5, 7));              // T junction
        send_pair(mk_pair(0, 0, 10, 0, 5, 1, 5, 7));              // T near miss
        send_pair(mk_pair(3, 3, 3, 3, 0, 0, 6, 6));               // point on segment
        send_pair(mk_pair(3, 4, 3, 4, 0, 0, 6, 6));               // point off the line
        send_pair(mk_pair(7, 7, 7, 7, 0, 0, 6, 6));               // point on line, past end
        send_pair(mk_pair(2, -3, 2, -3, 2, -3, 2, -3));           // equal points
        send_pair(mk_pair(2, -3, 2, -3, 2, -2, 2, -2));           // distinct points
        send_pair(mk_pair(2, -5, 2, 5, -5, 0, 5, 0));             // vertical x horizontal
        send_pair(mk_pair(0, -5, 0, 5, 0, 5, 0, 9));              // vertical, end to end
        send_pair(mk_pair(0, -5, 0, 5, 0, 6, 0, 9));              // vertical, apart
        send_pair(mk_pair(C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN));
        send_pair(mk_pair(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MAX));
        send_pair(mk_pair(C_MIN, C_MIN, 0, 0, 0, 0, C_MAX, C_MAX));
        send_pair(mk_pair(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN));
        send_pair(mk_pair(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX));
        send_pair(mk_pair(C_MAX, C_MIN, C_MIN, C_MAX, -1, 0, -1, 0));   // point on anti-diagonal
        send_pair(mk_pair(C_MAX, C_MIN, C_MIN, C_MAX, 0, 0, 0, 0));     // just off it
        send_pair(mk_pair(C_MIN, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MIN)); // corner
    endtask

    task automatic test_random_mix(input int count);
        for (int i = 0; i < count; i++)
        begin
            // stretches with and without sender gaps
            if (i % 64 == 0)
                gaps_on = ($urandom_range(2) != 0);
            send_pair(make_random_pair());
        end
    endtask

    // burst, then hold off until the pipeline has emptied, then burst again
    task automatic test_pause_until_drained();
        gaps_on = 1'b0;
        for (int i = 0; i < 20; i++)
            send_pair(make_random_pair());
        start <= 1'b0;
        do
            @(posedge clk);
        while (hit_expected_q.size() != 0);
        for (int i = 0; i < 20; i++)
            send_pair(make_random_pair());
    endtask

    task automatic test_back_to_back(input int count);
        gaps_on = 1'b0;
        for (int i = 0; i < count; i++)
            send_pair(make_random_pair());
    endtask

    // ------------------------------------------------------------------
    // Result checker and progress counter
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            if ((start && !busy) || done)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (done)
            begin
                if (hit_expected_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with no request pending: expected none, actual %0b",
                             $time, intersects);
                end
                else
                begin
                    head_rec = hit_expected_q.pop_front();
                    pairs_checked++;
                    if (head_rec.hit)
                        hits_seen++;
                    if (intersects !== head_rec.hit)
                    begin
                        errors++;
                        $display("%0t: intersects mismatch: expected %0b, actual %0b",
                                 $time, head_rec.hit, intersects);
                        $display("    A (%0d,%0d)-(%0d,%0d)  B (%0d,%0d)-(%0d,%0d)",
                                 head_rec.pair.ax1, head_rec.pair.ay1,
                                 head_rec.pair.ax2, head_rec.pair.ay2,
                                 head_rec.pair.bx1, head_rec.pair.by1,
                                 head_rec.pair.bx2, head_rec.pair.by2);
                    end
                end
            end
        end
    end

    // no request accepted and no result for too long
    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("%0t: watchdog expired with %0d results outstanding",
                 $time, hit_expected_q.size());
        $display("segment_intersection_test_core regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n         = 1'b0;
        start         = 1'b0;
        seg_a_x1      = '0;
        seg_a_y1      = '0;
        seg_a_x2      = '0;
        seg_a_y2      = '0;
        seg_b_x1      = '0;
        seg_b_y1      = '0;
        seg_b_x2      = '0;
        seg_b_y2      = '0;
        gaps_on       = 1'b1;
        pairs_sent    = 0;
        pairs_checked = 0;
        hits_seen     = 0;
        errors        = 0;
        quiet_cycles  = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_corners();
        test_random_mix(1250);
        test_pause_until_drained();
        test_back_to_back(240);

        // drain, then watch a few more cycles for stray strobes
        start <= 1'b0;
        do
            @(posedge clk);
        while (hit_expected_q.size() != 0);
        repeat (PIPE_LATENCY + 4) @(posedge clk);

        $display("%0d segment pairs sent, %0d results checked (%0d touching, %0d apart)",
                 pairs_sent, pairs_checked, hits_seen, pairs_checked - hits_seen);
        $display("covered: directed corners, small grids, collinear runs, range extremes");
        if (errors == 0)
            $display("segment_intersection_test_core regression: pass");
        else
            $display("segment_intersection_test_core regression: fail");
        $finish;
    end

endmodule
